/* sv/rational_arithmetic_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit.
// Shared property shorthands used by the controller.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// An implication that must hold at every clock edge outside reset.
`define RAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// An implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/rau_pkg.sv */
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, error codes, widths and controller/datapath bundles.
// ---------------------------------------------------------------------------
package rau_pkg;

  localparam int WordBits = 32;
  localparam int CntBits = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_LT  = 3'd4,
    FUNC_GT  = 3'd5,
    FUNC_EQ  = 3'd6,
    FUNC_IPR = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_OPERAND = 2'd1,
    ERR_RESULT  = 2'd2
  } err_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul1;
    logic mul2;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic operand_zero;
    logic needs_lcm;
    logic gcd_done;
    logic div_done;
  } dp_status_t;

endpackage

/* sv/rau_datapath.sv */
// ---------------------------------------------------------------------------
// Rational arithmetic datapath
// Euclid gcd by a bit-serial remainder unit, divides for the lcm factors,
// two registered multiply steps and the result formation.
// ---------------------------------------------------------------------------
module rau_datapath (
  input  logic               clk,
  input  rau_pkg::dp_cmd_t    cmd,
  output rau_pkg::dp_status_t status,
  input  logic [2:0]          func,
  input  rau_pkg::word_t      a_num,
  input  rau_pkg::word_t      a_den,
  input  rau_pkg::word_t      b_num,
  input  rau_pkg::word_t      b_den,
  output rau_pkg::word_t      res_num,
  output rau_pkg::word_t      res_den,
  output logic                cmp_true,
  output logic [1:0]          error
);

  localparam int W = rau_pkg::WordBits;

  logic [2:0] op;
  rau_pkg::word_t an, ad, bn, bd;
  rau_pkg::word_t gx, gy;
  rau_pkg::word_t dvd, dvs, rem;
  logic [rau_pkg::CntBits-1:0] cnt;
  logic div_first;
  logic gcd_mode;
  rau_pkg::word_t ka, kb;
  rau_pkg::word_t p1, p2, p3;
  logic [W:0] trial;
  rau_pkg::word_t rem_sh;
  rau_pkg::word_t ma, mb;
  rau_pkg::word_t sb, rn, rd;
  logic lt_v, gt_v, eq_v;

  assign ma = ad[W-1] ? (~ad + 1'b1) : ad;
  assign mb = bd[W-1] ? (~bd + 1'b1) : bd;

  assign rem_sh = {rem[W-2:0], dvd[W-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs};

  // Euclid steps and the factor divisions share the same shift-subtract unit.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= func;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
    end
    if (cmd.load) begin
      gx <= a_den[W-1] ? (~a_den + 1'b1) : a_den;
      gy <= b_den[W-1] ? (~b_den + 1'b1) : b_den;
      div_first <= 1'b1;
      gcd_mode <= 1'b1;
    end else if (cmd.gcd_step) begin
      dvd <= gx;
      dvs <= gy;
      rem <= '0;
      cnt <= rau_pkg::CntBits'(W);
    end else if (cmd.div_init) begin
      dvd <= div_first ? mb : ma;
      dvs <= gx;
      rem <= '0;
      cnt <= rau_pkg::CntBits'(W);
      gcd_mode <= 1'b0;
    end else if (cmd.div_step) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        dvd <= {dvd[W-2:0], ~trial[W]};
        rem <= trial[W] ? rem_sh : trial[W-1:0];
      end else if (gcd_mode) begin
        gx <= gy;
        gy <= rem;
      end else if (div_first) begin
        ka <= dvd;
        div_first <= 1'b0;
      end else begin
        kb <= dvd;
      end
    end
    if (cmd.mul1) begin
      p1 <= W'(ka * an);
      p2 <= W'(kb * bn);
      p3 <= W'(ad * ka);
    end
    if (cmd.mul2) begin
      case (op)
        rau_pkg::FUNC_MUL: begin
          p1 <= W'(an * bn);
          p3 <= W'(ad * bd);
        end
        rau_pkg::FUNC_DIV: begin
          p1 <= W'(an * bd);
          p3 <= W'(ad * bn);
        end
        default: begin
          p1 <= W'(an * bd) + bn;
          p3 <= bd;
        end
      endcase
    end
  end

  assign status.operand_zero = (bd == '0) || (op != rau_pkg::FUNC_IPR && ad == '0);
  assign status.needs_lcm = (op == rau_pkg::FUNC_ADD) || (op == rau_pkg::FUNC_SUB) ||
                            (op == rau_pkg::FUNC_LT) || (op == rau_pkg::FUNC_GT) ||
                            (op == rau_pkg::FUNC_EQ);
  assign status.gcd_done = (gy == '0);
  assign status.div_done = (cnt == '0);

  assign sb = (ad[W-1] != bd[W-1]) ? (~p2 + 1'b1) : p2;
  assign lt_v = $signed(p1) < $signed(sb);
  assign gt_v = $signed(p1) > $signed(sb);
  assign eq_v = (p1 == sb);

  always_comb begin
    rn = p1;
    rd = p3;
    case (op)
      rau_pkg::FUNC_ADD: rn = p1 + sb;
      rau_pkg::FUNC_SUB: rn = p1 - sb;
      default: rn = p1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_num <= '0;
      res_den <= '0;
      cmp_true <= 1'b0;
      error <= rau_pkg::ERR_OK;
      if (status.operand_zero) begin
        error <= rau_pkg::ERR_OPERAND;
      end else if (op == rau_pkg::FUNC_LT) begin
        cmp_true <= lt_v;
      end else if (op == rau_pkg::FUNC_GT) begin
        cmp_true <= gt_v;
      end else if (op == rau_pkg::FUNC_EQ) begin
        cmp_true <= eq_v;
      end else if (rd == '0) begin
        error <= rau_pkg::ERR_RESULT;
      end else begin
        res_num <= rn;
        res_den <= rd;
      end
    end
  end

endmodule

/* sv/rau_ctrl.sv */
// ---------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences gcd iterations, factor divisions, multiplies and the output hold.
// ---------------------------------------------------------------------------
`include "rational_arithmetic_unit_assert.svh"

module rau_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rau_pkg::dp_cmd_t    cmd,
  input  rau_pkg::dp_status_t status
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_GCD   = 9'b000000100,
    S_GDIV  = 9'b000001000,
    S_KINIT = 9'b000010000,
    S_KDIV  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic second_k, second_k_next;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    second_k_next = second_k;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.operand_zero) begin
          state_next = S_FIN;
        end else if (status.needs_lcm) begin
          state_next = S_GCD;
        end else begin
          cmd.mul2 = 1'b1;
          state_next = S_FIN;
        end
      end
      S_GCD: begin
        if (status.gcd_done) begin
          cmd.div_init = 1'b1;
          second_k_next = 1'b0;
          state_next = S_KDIV;
        end else begin
          cmd.gcd_step = 1'b1;
          state_next = S_GDIV;
        end
      end
      S_GDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_GCD;
        end
      end
      S_KINIT: begin
        cmd.div_init = 1'b1;
        second_k_next = 1'b1;
        state_next = S_KDIV;
      end
      S_KDIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = second_k ? S_MUL : S_KINIT;
        end
      end
      S_MUL: begin
        cmd.mul1 = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = S_CHECK;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      second_k <= 1'b0;
    end else begin
      state <= state_next;
      second_k <= second_k_next;
    end
  end

  `RAU_ASSERT_IMP(a_onehot, 1'b1, $onehot(state))
  `RAU_ASSERT_NEXT(a_fin_out, cmd.finish, out_valid)
  `RAU_ASSERT_IMP(a_load_ready, cmd.load, in_ready && in_valid)
  `RAU_ASSERT_IMP(a_no_load_busy, out_valid && !out_ready, !cmd.load)

endmodule

/* sv/rational_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide, compare and integer-plus-rational on
// unreduced 32-bit rationals.
// ---------------------------------------------------------------------------
// One item is processed at a time. Multiply, divide and integer plus rational
// form the products in the check state and register the result in the finish
// state. Add, subtract and the comparisons run Euclid's gcd on the denominator
// magnitudes, each remainder formed in the one-bit-per-cycle shift-subtract
// unit, then two divisions for the scale factors, a multiply step and the
// finish step. A finished result is held in the output register and the next
// item can be taken in the same cycle as the result is accepted.
module rational_arithmetic_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero fill
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[31:0], res_den[63:32], cmp_true[64], error[66:65], zero fill
  output logic [71:0]  m_axis_tdata
);

  rau_pkg::dp_cmd_t cmd;
  rau_pkg::dp_status_t status;
  rau_pkg::word_t res_num, res_den;
  logic cmp_true;
  logic [1:0] error;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  rau_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .status   (status),
    .func     (s_axis_tdata[2:0]),
    .a_num    (s_axis_tdata[34:3]),
    .a_den    (s_axis_tdata[66:35]),
    .b_num    (s_axis_tdata[98:67]),
    .b_den    (s_axis_tdata[130:99]),
    .res_num  (res_num),
    .res_den  (res_den),
    .cmp_true (cmp_true),
    .error    (error)
  );

  assign m_axis_tdata = {5'd0, error, cmp_true, res_den, res_num};

endmodule
